@@ src/hdec_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdec_pkg
// Shared types and constants of the Huffman table decoder: command codes,
// input beat layout, table entry layout, controller states and the command
// and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package hdec_pkg;

  localparam int CMD_W   = 2;
  localparam int IDX_W   = 8;
  localparam int CODE_W  = 16;
  localparam int LEN_W   = 5;
  localparam int SYM_W   = 8;
  localparam int BYTE_W  = 8;
  localparam int COUNT_W = 24;
  localparam int CMP_W   = 6;
  localparam int BIT_CNT_W = 3;

  // input tdata layout, lowest bit first
  localparam int IDX_LSB  = 0;
  localparam int CODE_LSB = IDX_LSB + IDX_W;
  localparam int LEN_LSB  = CODE_LSB + CODE_W;
  localparam int SYM_LSB  = LEN_LSB + LEN_W;
  localparam int BYTE_LSB = SYM_LSB + SYM_W;
  localparam int IN_DATA_W = 48;

  localparam int OUT_USER_W = 2;

  localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_START = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DATA  = 2'd2;

  localparam logic [BIT_CNT_W-1:0] LAST_BIT = 3'd7;

  typedef struct packed {
    logic [SYM_W-1:0]  sym;
    logic [LEN_W-1:0]  len;
    logic [CODE_W-1:0] code;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_SCAN,
    ST_RESULT,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic load_entry;
    logic start;
    logic take_byte;
    logic shift_bit;
    logic scan_step;
    logic emit;
    logic flush;
    logic next_bit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic byte_ok;
    logic hit;
    logic scan_done;
    logic at_max;
    logic last_bit;
    logic left_one;
    logic hold_valid;
    logic out_free;
  } ctrl_sts_t;

endpackage

@@ src/hdec_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdec_datapath
// Code table memory, valid marks, code accumulator, table scan, symbol
// counter, one held result and the output register.
// ----------------------------------------------------------------------------
module hdec_datapath import hdec_pkg::*; #(
  parameter int MAX_CODE_LEN  = 16,
  parameter int TABLE_ENTRIES = 256
) (
  input  logic                  clk,
  input  logic                  rst,
  input  ctrl_cmd_t             cmd,
  output ctrl_sts_t             sts,
  input  logic [IN_DATA_W-1:0]  s_tdata,
  input  logic                  cfg_valid,
  input  logic [COUNT_W-1:0]    cfg_data,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [SYM_W-1:0]      m_tdata,
  output logic                  m_tlast,
  output logic [OUT_USER_W-1:0] m_tuser
);

  localparam int AW = $clog2(TABLE_ENTRIES);
  localparam int PW = AW + 1;
  localparam int CW = MAX_CODE_LEN;
  localparam int LW = $clog2(MAX_CODE_LEN + 1);

  logic [IDX_W-1:0]  in_idx;
  logic [BYTE_W-1:0] in_byte;
  entry_t            in_entry;
  logic              idx_ok;
  logic [AW-1:0]     slot;
  logic [PW-1:0]     new_top;

  entry_t              entry_mem [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] entry_valid;
  logic [PW-1:0]       fill_top;

  logic [COUNT_W-1:0]  symbol_count;
  logic [COUNT_W-1:0]  symbols_left;
  logic [CW-1:0]       accum_code;
  logic [LW-1:0]       accum_len;
  logic [BYTE_W-1:0]   byte_reg;
  logic [BIT_CNT_W-1:0] bit_cnt;

  logic [PW-1:0]       scan_addr;
  logic                scan_more;
  logic                pv;
  logic                rd_vld;
  entry_t              rd_entry;
  logic [31:0]         rd_code_ext;
  logic [CW-1:0]       expect_code;
  logic                hit;

  logic                hold_valid;
  logic [SYM_W-1:0]    hold_sym;
  logic                hold_done;
  logic                hold_err;
  logic                out_valid;
  logic                out_free;

  assign in_idx        = s_tdata[IDX_LSB +: IDX_W];
  assign in_byte       = s_tdata[BYTE_LSB +: BYTE_W];
  assign in_entry.code = s_tdata[CODE_LSB +: CODE_W];
  assign in_entry.len  = s_tdata[LEN_LSB +: LEN_W];
  assign in_entry.sym  = s_tdata[SYM_LSB +: SYM_W];

  assign idx_ok  = {1'b0, in_idx} < 9'(TABLE_ENTRIES);
  assign slot    = in_idx[AW-1:0];
  assign new_top = {1'b0, slot} + PW'(1);

  assign scan_more = scan_addr < fill_top;

  // code bits above the accumulated length compare as zero
  assign rd_code_ext = 32'(rd_entry.code);
  always_comb begin
    for (int i = 0; i < CW; i++) begin
      expect_code[i] = (LW'(i) < accum_len) ? rd_code_ext[i] : 1'b0;
    end
  end

  assign hit = pv && rd_vld && (CMP_W'(rd_entry.len) == CMP_W'(accum_len)) &&
               (expect_code == accum_code);

  assign out_free = !out_valid || m_tready;

  assign sts.byte_ok    = symbols_left != '0;
  assign sts.hit        = hit;
  assign sts.scan_done  = !pv && !scan_more;
  assign sts.at_max     = accum_len >= LW'(MAX_CODE_LEN);
  assign sts.last_bit   = bit_cnt == LAST_BIT;
  assign sts.left_one   = symbols_left == COUNT_W'(1);
  assign sts.hold_valid = hold_valid;
  assign sts.out_free   = out_free;

  always_ff @(posedge clk) begin
    if (cmd.load_entry && idx_ok) begin
      entry_mem[slot] <= in_entry;
    end
    if (cmd.scan_step && scan_more) begin
      rd_entry <= entry_mem[scan_addr[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid  <= '0;
      fill_top     <= '0;
      symbol_count <= '0;
      symbols_left <= '0;
      accum_code   <= '0;
      accum_len    <= '0;
      bit_cnt      <= '0;
      scan_addr    <= '0;
      pv           <= 1'b0;
      hold_valid   <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_valid) begin
        symbol_count <= cfg_data;
      end
      if (cmd.load_entry && idx_ok) begin
        entry_valid[slot] <= 1'b1;
        if (new_top > fill_top) begin
          fill_top <= new_top;
        end
      end
      if (cmd.start) begin
        accum_code   <= '0;
        accum_len    <= '0;
        symbols_left <= symbol_count;
      end
      if (cmd.take_byte) begin
        bit_cnt <= '0;
      end
      if (cmd.next_bit) begin
        bit_cnt <= bit_cnt + BIT_CNT_W'(1);
      end
      if (cmd.shift_bit) begin
        accum_code <= CW'({accum_code, byte_reg[BYTE_W-1]});
        accum_len  <= accum_len + LW'(1);
        scan_addr  <= '0;
        pv         <= 1'b0;
      end
      if (cmd.scan_step) begin
        if (scan_more) begin
          pv        <= 1'b1;
          scan_addr <= scan_addr + PW'(1);
        end else begin
          pv <= 1'b0;
        end
      end
      if (cmd.emit) begin
        accum_code <= '0;
        accum_len  <= '0;
        hold_valid <= 1'b1;
        if (hit) begin
          symbols_left <= symbols_left - COUNT_W'(1);
        end
      end
      if (cmd.flush) begin
        hold_valid <= 1'b0;
      end
      if ((cmd.emit && hold_valid) || cmd.flush) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_byte) begin
      byte_reg <= in_byte;
    end else if (cmd.shift_bit) begin
      byte_reg <= {byte_reg[BYTE_W-2:0], 1'b0};
    end
    if (cmd.scan_step && scan_more) begin
      rd_vld <= entry_valid[scan_addr[AW-1:0]];
    end
    if (cmd.emit) begin
      hold_sym  <= hit ? rd_entry.sym : '0;
      hold_done <= hit && sts.left_one;
      hold_err  <= !hit;
    end
    // the held result goes out with tlast only when the byte is finished
    if ((cmd.emit && hold_valid) || cmd.flush) begin
      m_tdata <= hold_sym;
      m_tlast <= cmd.flush;
      m_tuser <= {hold_err, hold_done};
    end
  end

  assign m_tvalid = out_valid;

endmodule

@@ src/hdec_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdec_ctrl
// Sequencer: takes commands, walks the bits of a data byte (at most eight), runs
// one table scan per bit and hands results to the datapath.
// ----------------------------------------------------------------------------
module hdec_ctrl import hdec_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [CMD_W-1:0] s_tuser,
  input  ctrl_sts_t        sts,
  output ctrl_cmd_t        cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          case (s_tuser)
            CMD_LOAD:  cmd.load_entry = 1'b1;
            CMD_START: cmd.start = 1'b1;
            CMD_DATA: begin
              // drop bytes while no symbols are left
              if (sts.byte_ok) begin
                cmd.take_byte = 1'b1;
                state_next    = ST_SHIFT;
              end
            end
            default: ;
          endcase
        end
      end
      ST_SHIFT: begin
        cmd.shift_bit = 1'b1;
        state_next    = ST_SCAN;
      end
      ST_SCAN: begin
        if (sts.hit) begin
          state_next = ST_RESULT;
        end else if (sts.scan_done) begin
          if (sts.at_max) begin
            state_next = ST_RESULT;
          end else if (sts.last_bit) begin
            state_next = ST_FLUSH;
          end else begin
            cmd.next_bit = 1'b1;
            state_next   = ST_SHIFT;
          end
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      ST_RESULT: begin
        if (!sts.hold_valid || sts.out_free) begin
          cmd.emit = 1'b1;
          if ((sts.hit && sts.left_one) || sts.last_bit) begin
            state_next = ST_FLUSH;
          end else begin
            cmd.next_bit = 1'b1;
            state_next   = ST_SHIFT;
          end
        end
      end
      ST_FLUSH: begin
        if (!sts.hold_valid) begin
          state_next = ST_IDLE;
        end else if (sts.out_free) begin
          cmd.flush  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

@@ src/huffman_table_decoder_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// huffman_table_decoder_unit
// Table-driven Huffman decoder with a loadable code table.
// ----------------------------------------------------------------------------
// Load and start beats are taken in the idle state. A data byte is decoded one bit at
// a time. The code table memory is scanned one entry per cycle from slot 0 up
// to the highest slot loaded so far, and the scan stops at the first match.
// With the default maximum code length a byte holds at most one code error,
// and m_tready can hold a result back and stall the decode. A byte's results
// leave in order through one held result and an output register; the last
// result of a byte carries tlast. Valid marks of the table are cleared by
// reset at once, no clearing pass.
module huffman_table_decoder_unit import hdec_pkg::*; #(
  parameter int MAX_CODE_LEN  = 16,
  parameter int TABLE_ENTRIES = 256
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // entry_index, code_bits, code_len, entry_symbol, data_byte, zero pad
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // cmd
  input  logic [CMD_W-1:0]      s_tuser,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [COUNT_W-1:0]    cfg_data,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // symbol
  output logic [SYM_W-1:0]      m_tdata,
  output logic                  m_tlast,
  // done_res, error
  output logic [OUT_USER_W-1:0] m_tuser
);

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  assign cfg_ready = 1'b1;

  hdec_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .sts      (sts),
    .cmd      (cmd)
  );

  hdec_datapath #(
    .MAX_CODE_LEN  (MAX_CODE_LEN),
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .s_tdata   (s_tdata),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser)
  );

endmodule

@@ tb/tb_huffman_table_decoder_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_huffman_table_decoder_unit
// Self-checking bench for the table-driven Huffman decoder. A queue of beats
// feeds a stream driver; every accepted beat updates a bench-side copy of the
// code table and decode state, which queues the symbols it should yield. A
// monitor compares each output beat with the oldest queued symbol. Phases
// vary the symbol count register and the idle/stall pattern on both sides.
// ----------------------------------------------------------------------------
module tb_huffman_table_decoder_unit;
  import hdec_pkg::*;

  localparam int CLK_PERIOD   = 10;
  localparam int RESET_CYCLES = 12;
  localparam int MAX_LEN      = 16;
  localparam int N_SLOTS      = 256;
  localparam int STALL_LIMIT  = 40000;
  localparam int MAX_REPORTS  = 30;
  localparam int DONE_BIT     = 0;
  localparam int ERR_BIT      = 1;

  localparam logic [CMD_W-1:0]   CMD_UNUSED = 2'd3;
  localparam logic [COUNT_W-1:0] COUNT_MAX  = '1;

  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_t;

  typedef struct packed {
    logic [CMD_W-1:0]     cmd;
    logic [IN_DATA_W-1:0] data;
  } in_beat_t;

  typedef struct packed {
    logic [SYM_W-1:0] sym;
    logic             last;
    logic             done;
    logic             err;
  } dec_result_t;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata   = '0;
  logic [CMD_W-1:0]      s_tuser   = '0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [COUNT_W-1:0]    cfg_data  = '0;
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [SYM_W-1:0]      m_tdata;
  logic                  m_tlast;
  logic [OUT_USER_W-1:0] m_tuser;

  huffman_table_decoder_unit #(
    .MAX_CODE_LEN (MAX_LEN),
    .TABLE_ENTRIES(N_SLOTS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Decoder state as the bench sees it
  logic [COUNT_W-1:0] count_reg;
  logic               tbl_valid [N_SLOTS];
  logic [CODE_W-1:0]  tbl_code  [N_SLOTS];
  logic [LEN_W-1:0]   tbl_len   [N_SLOTS];
  logic [SYM_W-1:0]   tbl_sym   [N_SLOTS];
  logic [CODE_W-1:0]  acc_code;
  logic [LEN_W-1:0]   acc_len;
  logic [COUNT_W-1:0] syms_left;
  int                 top_slot;

  in_beat_t    beats_to_send [$];
  dec_result_t symbols_due   [$];
  in_beat_t    next_beat;
  dec_result_t due_now;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int items_queued = 0;
  int beats_taken = 0;
  int results_seen = 0;
  int errors_seen = 0;
  int count_ends = 0;
  int settings_used = 0;
  int mismatches = 0;
  int idle_cycles = 0;
  logic in_fire = 1'b0;

  task automatic report_mismatch(input string msg);
    if (mismatches < MAX_REPORTS) $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [SYM_W-1:0] got,
                             input logic [SYM_W-1:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s: got %0h, want %0h",
                                results_seen, name, got, want));
  endtask

  // Apply one accepted beat to the table and decode state; queue its symbols.
  task automatic decode_beat(input logic [CMD_W-1:0] cmd,
                             input logic [IN_DATA_W-1:0] data);
    logic [IDX_W-1:0]  idx;
    logic [BYTE_W-1:0] bits;
    logic [CODE_W-1:0] mask;
    dec_result_t       res [$];
    dec_result_t       r;
    int                hit;
    idx  = data[IDX_LSB +: IDX_W];
    bits = data[BYTE_LSB +: BYTE_W];
    case (cmd)
      CMD_LOAD: begin
        tbl_valid[idx] = 1'b1;
        tbl_code[idx]  = data[CODE_LSB +: CODE_W];
        tbl_len[idx]   = data[LEN_LSB +: LEN_W];
        tbl_sym[idx]   = data[SYM_LSB +: SYM_W];
        if (int'(idx) > top_slot) top_slot = int'(idx);
      end
      CMD_START: begin
        acc_code  = '0;
        acc_len   = '0;
        syms_left = count_reg;
      end
      CMD_DATA: begin
        // MSB first; drop the rest of the byte once the count runs out
        for (int b = BYTE_W - 1; b >= 0 && syms_left != 0; b--) begin
          acc_code = {acc_code[CODE_W-2:0], bits[b]};
          acc_len  = acc_len + 1'b1;
          mask     = CODE_W'((32'd1 << acc_len) - 32'd1);
          hit      = -1;
          for (int i = 0; i < N_SLOTS && hit < 0; i++)
            if (tbl_valid[i] && tbl_len[i] == acc_len && (tbl_code[i] & mask) == acc_code)
              hit = i;
          r = '0;
          if (hit >= 0) begin
            syms_left = syms_left - 1'b1;
            r.sym     = tbl_sym[hit];
            r.done    = (syms_left == 0);
            res.push_back(r);
            acc_code  = '0;
            acc_len   = '0;
          end else if (acc_len >= MAX_LEN) begin
            r.err    = 1'b1;
            res.push_back(r);
            acc_code = '0;
            acc_len  = '0;
          end
        end
        if (res.size() > 0) res[res.size() - 1].last = 1'b1;
        foreach (res[k]) symbols_due.push_back(res[k]);
      end
      default: ;
    endcase
  endtask

  // Input side: sample at the rising edge, drive at the falling edge
  always @(posedge clk) begin
    if (rst) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= s_tvalid && s_tready;
      if (s_tvalid && s_tready) begin
        decode_beat(s_tuser, s_tdata);
        beats_taken++;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || in_fire) begin
      if (beats_to_send.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        next_beat = beats_to_send.pop_front();
        s_tvalid <= 1'b1;
        s_tuser  <= next_beat.cmd;
        s_tdata  <= next_beat.data;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Output side
  always @(negedge clk) begin
    m_tready <= !rst && ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (symbols_due.size() == 0) begin
        report_mismatch($sformatf("result %0d with nothing expected: sym %0h user %b",
                                  results_seen, m_tdata, m_tuser));
      end else begin
        due_now = symbols_due.pop_front();
        check_field("symbol", m_tdata, due_now.sym);
        check_field("last", SYM_W'(m_tlast), SYM_W'(due_now.last));
        check_field("done", SYM_W'(m_tuser[DONE_BIT]), SYM_W'(due_now.done));
        check_field("error", SYM_W'(m_tuser[ERR_BIT]), SYM_W'(due_now.err));
        if (due_now.err) errors_seen++;
        if (due_now.done) count_ends++;
      end
    end
  end

  // Watchdog: end the run if no beat moves anywhere for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Timeout: no beat accepted for %0d cycles", STALL_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic [IN_DATA_W-1:0] pack_fields(
    input logic [IDX_W-1:0] idx, input logic [CODE_W-1:0] code,
    input logic [LEN_W-1:0] len, input logic [SYM_W-1:0] sym,
    input logic [BYTE_W-1:0] dbyte);
    logic [IN_DATA_W-1:0] word;
    word = '0;
    word[IDX_LSB +: IDX_W]   = idx;
    word[CODE_LSB +: CODE_W] = code;
    word[LEN_LSB +: LEN_W]   = len;
    word[SYM_LSB +: SYM_W]   = sym;
    word[BYTE_LSB +: BYTE_W] = dbyte;
    return word;
  endfunction

  task automatic queue_beat(input logic [CMD_W-1:0] cmd, input logic [IN_DATA_W-1:0] data);
    in_beat_t b;
    b.cmd  = cmd;
    b.data = data;
    beats_to_send.push_back(b);
    items_queued++;
  endtask

  task automatic queue_load(input logic [IDX_W-1:0] idx, input logic [CODE_W-1:0] code,
                            input logic [LEN_W-1:0] len, input logic [SYM_W-1:0] sym);
    queue_beat(CMD_LOAD, pack_fields(idx, code, len, sym, BYTE_W'($urandom)));
  endtask

  task automatic queue_byte(input logic [BYTE_W-1:0] dbyte);
    queue_beat(CMD_DATA, pack_fields(IDX_W'($urandom), CODE_W'($urandom), LEN_W'($urandom),
                                     SYM_W'($urandom), dbyte));
  endtask

  task automatic queue_other(input logic [CMD_W-1:0] cmd);
    queue_beat(cmd, pack_fields(IDX_W'($urandom), CODE_W'($urandom), LEN_W'($urandom),
                                SYM_W'($urandom), BYTE_W'($urandom)));
  endtask

  // Mostly short codes so symbols come often; some long, zero or oversize lengths
  function automatic logic [LEN_W-1:0] pick_len();
    int roll = $urandom_range(99);
    if (roll < 75) return LEN_W'($urandom_range(4, 1));
    if (roll < 90) return LEN_W'($urandom_range(MAX_LEN, 5));
    if (roll < 95) return '0;
    return LEN_W'($urandom_range(31, MAX_LEN + 1));
  endfunction

  // A few loads, a start, then a run of random bytes; now and then skip the
  // start or slip in a stray command
  task automatic queue_sequence(input int max_slot);
    int n_loads = $urandom_range(6, 1);
    int n_bytes = $urandom_range(8, 2);
    repeat (n_loads) queue_load(IDX_W'($urandom_range(max_slot, 0)), CODE_W'($urandom),
                                pick_len(), SYM_W'($urandom));
    if ($urandom_range(9) != 0) queue_other(CMD_START);
    repeat (n_bytes) begin
      case ($urandom_range(24))
        0: queue_other(CMD_UNUSED);
        1: queue_other(CMD_START);
        default: ;
      endcase
      queue_byte(BYTE_W'($urandom));
    end
  endtask

  // Wait until all queued beats are taken and every symbol has come out, then
  // allow one full byte decode with the current table size.
  task automatic settle();
    while (beats_to_send.size() != 0 || s_tvalid || symbols_due.size() != 0)
      @(posedge clk);
    repeat (8 * (top_slot + 3) + 10) @(posedge clk);
  endtask

  task automatic write_count(input logic [COUNT_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    count_reg = val;
    settings_used++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_idling(input idle_mode_t mode);
    case (mode)
      IDLE_SENDER:   begin send_idle_pct = 54; recv_stall_pct = 0;  end
      IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 54; end
      IDLE_BOTH:     begin send_idle_pct = 16; recv_stall_pct = 16; end
      default:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
    endcase
  endtask

  task automatic run_phase(input logic [COUNT_W-1:0] count_val, input idle_mode_t mode,
                           input int n_items, input int max_slot);
    int target;
    settle();
    write_count(count_val);
    set_idling(mode);
    target = items_queued + n_items;
    while (items_queued < target) queue_sequence(max_slot);
  endtask

  initial begin
    for (int i = 0; i < N_SLOTS; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_code[i]  = '0;
      tbl_len[i]   = '0;
      tbl_sym[i]   = '0;
    end
    count_reg = '0;
    acc_code  = '0;
    acc_len   = '0;
    syms_left = '0;
    top_slot  = 0;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: count of three, no idling
    write_count(COUNT_W'(3));
    queue_other(CMD_UNUSED);
    queue_byte(8'hA5);                        // no start yet: ignored
    queue_load(8'd0, 16'h0000, 5'd1, 8'h11);
    queue_load(8'd5, 16'h0002, 5'd2, 8'h22);
    queue_load(8'd3, 16'hFFF2, 5'd2, 8'h33);  // same code as slot 5, lower slot wins
    queue_load(8'd7, 16'h0000, 5'd0, 8'h44);  // zero length never matches
    queue_load(8'd8, 16'h0001, 5'd17, 8'h55); // longer than max never matches
    queue_load(8'd9, 16'hFFFF, 5'd31, 8'h66);
    queue_load(8'd10, 16'hFFFF, 5'd16, 8'hFF);
    queue_other(CMD_START);
    queue_byte(8'h00);                        // count ends mid-byte
    queue_byte(8'h00);                        // count exhausted: ignored
    queue_other(CMD_START);
    queue_byte(8'h80);
    queue_other(CMD_START);
    queue_load(8'd0, 16'h0000, 5'd16, 8'hF0); // overwrite a live slot
    queue_byte(8'h00);
    queue_byte(8'h00);                        // all-zero 16-bit code
    queue_byte(8'h00);
    queue_byte(8'hFF);                        // 16 bits, no match: error
    queue_byte(8'hFF);
    queue_byte(8'hFF);                        // all-ones 16-bit code
    queue_byte(8'h81);

    run_phase(COUNT_W'(1), IDLE_SENDER, 36, 15);
    run_phase(COUNT_MAX, IDLE_RECEIVER, 40, 31);
    run_phase('0, IDLE_BOTH, 12, 31);          // start with zero count stays idle
    run_phase(COUNT_W'(17), IDLE_NONE, 40, 31);
    run_phase(COUNT_W'($urandom_range(60, 2)), IDLE_SENDER, 40, 31);
    run_phase(COUNT_W'(2), IDLE_RECEIVER, 36, 31);
    run_phase(COUNT_W'($urandom), IDLE_BOTH, 40, 31);
    // Whole table last: loads may go to any slot, so scans can run over the whole table
    run_phase(COUNT_W'(40), IDLE_NONE, 30, N_SLOTS - 1);
    settle();

    $display("Covered %0d input beats and %0d result beats (%0d code errors, %0d count ends)",
             beats_taken, results_seen, errors_seen, count_ends);
    $display("over %0d symbol count settings, %0d mismatches", settings_used, mismatches);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/hdec_pkg.sv
src/hdec_datapath.sv
src/hdec_ctrl.sv
src/huffman_table_decoder_unit.sv
tb/tb_huffman_table_decoder_unit.sv
